### design/rotary_indexer_position_tracker_top_macros.svh
// Assertion helpers shared by the indexer tracker modules.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef ROTARY_INDEXER_POSITION_TRACKER_TOP_MACROS_SVH
`define ROTARY_INDEXER_POSITION_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define RIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rip_pkg.sv
package rip_pkg;

    // Fixed field widths of the item formats
    localparam int FIELD_W   = 24;
    localparam int COUNT_W   = 7;
    localparam int IDX_W     = 6;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [OP_W-1:0] OP_MOVE   = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd1;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd2;
    localparam logic [OP_W-1:0] OP_ZERO   = 3'd3;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MOVE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CAL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZEROED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIONS_PER_REV = 1'd1;

    // Register reset values
    localparam int SPR_RESET = 3200;
    localparam int PPR_RESET = 6;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          target_index;
        logic signed [FIELD_W-1:0] completed_steps;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] requested_steps;
        logic [STATUS_W-1:0]       status;
        logic [FIELD_W-1:0]        position_steps;
        logic [IDX_W-1:0]          nearest_index;
    } t_out_item;

endpackage

### design/rip_serial_div.sv
`include "rotary_indexer_position_tracker_top_macros.svh"

module rip_serial_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 24,
    parameter int QUO_W = 24,
    parameter int MOD_W = 7,
    parameter int LEN_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [LEN_W-1:0] i_len,
    input  logic [DEN_W-1:0] i_den,
    input  logic [MOD_W-1:0] i_modn,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [MOD_W-1:0] o_qmod
);

    localparam int SEL_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [MOD_W-1:0] r_modn, n_modn;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [MOD_W-1:0] r_qm, n_qm;

    logic [SEL_W-1:0] bit_sel;
    logic             cur_bit;
    logic [DEN_W:0]   trial;
    logic             q_bit;
    logic [MOD_W:0]   m_trial;
    logic             m_ge;

    // Pick the next numerator bit, MSB of the active length first
    assign bit_sel = SEL_W'(r_cnt - LEN_W'(1));
    assign cur_bit = r_num[bit_sel];

    // One restoring step: shift in a bit, subtract when it fits
    assign trial   = {r_rem, cur_bit};
    assign q_bit   = (trial >= {1'b0, r_den});
    // Fold the quotient bit into the running quotient mod count
    assign m_trial = {r_qm, q_bit};
    assign m_ge    = (m_trial >= {1'b0, r_modn});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_modn = r_modn;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_qm   = r_qm;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_len;
            n_num  = i_num;
            n_den  = i_den;
            n_modn = i_modn;
            n_rem  = '0;
            n_quo  = '0;
            n_qm   = '0;
        end else if (r_busy) begin
            n_rem = q_bit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], q_bit};
            n_qm  = m_ge ? MOD_W'(m_trial - {1'b0, r_modn}) : m_trial[MOD_W-1:0];
            n_cnt = r_cnt - LEN_W'(1);
            if (r_cnt == LEN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Shift registers and operands
    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_modn <= n_modn;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_qm   <= n_qm;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_qmod = r_qm;

    `RIP_ASSERT_IMP(a_no_restart, i_start, !r_busy, "divider restarted while busy")
    `RIP_ASSERT_IMP(a_rem_below_den, r_busy && (r_den != '0), r_rem < r_den, "partial remainder not below divisor")
    `RIP_ASSERT_NXT(a_last_step_done, r_busy && (r_cnt == LEN_W'(1)) && !i_start, r_done && !r_busy, "last step did not flag done")

endmodule

### design/rotary_indexer_position_tracker_top.sv
// A completion report runs one more division when the sum leaves the revolution; a move to
// an index runs one more from a position past a shortened revolution, and so do next and
// previous. One command in work; a bit-serial divider, one quotient bit a cycle, runs up to
// four divisions per command; the block takes the next command while a result waits in the
// output register. Sync active-low reset clears position and pending, loads 3200/6.
`include "rotary_indexer_position_tracker_top_macros.svh"

module rotary_indexer_position_tracker_top #(
    parameter int STEP_BITS     = 24,
    parameter int MAX_POSITIONS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  rip_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output rip_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rip_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rip_pkg::FIELD_W-1:0]          i_cfg_data
);

    import rip_pkg::*;

    localparam int SW   = (STEP_BITS < FIELD_W) ? STEP_BITS : FIELD_W;
    localparam int CW   = COUNT_W;
    localparam int DW   = (SW > 8) ? SW : 8;
    localparam int NW   = (SW + CW + 1 > FIELD_W + 1) ? SW + CW + 1 : FIELD_W + 1;
    localparam int LW   = $clog2(NW + 1);
    localparam int VW   = FIELD_W + 2;
    localparam int MAGW = VW - 1;
    localparam int RW   = SW + 2;
    localparam int MAXC = (MAX_POSITIONS > 127) ? 127 : MAX_POSITIONS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PLAN  = 9'b000000010,
        S_START = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_ROUTE = 9'b001000000,
        S_NEAR  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        J_NEAR_PRE,
        J_POSMOD,
        J_TARGET,
        J_WRAP,
        J_TGTMOD,
        J_NEAR_OUT
    } t_job;

    // Tracker state and configuration
    t_state                    r_state, n_state;
    t_job                      r_job, n_job;
    logic [SW-1:0]             r_spr, n_spr;
    logic [CW-1:0]             r_ppr, n_ppr;
    logic [SW-1:0]             r_pos, n_pos;
    logic [SW-1:0]             r_ptgt, n_ptgt;
    logic signed [FIELD_W-1:0] r_preq, n_preq;
    logic                      r_pend, n_pend;
    logic                      r_ovalid, n_ovalid;

    // Command in work
    logic [OP_W-1:0]           r_op, n_op;
    logic [CW-1:0]             r_idx, n_idx;
    logic signed [FIELD_W-1:0] r_done_steps, n_done_steps;
    logic [NW-1:0]             r_acc, n_acc;
    logic [SW-1:0]             r_pm, n_pm;
    logic signed [RW-1:0]      r_diff, n_diff;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [CW-1:0]             r_near, n_near;
    t_out_item                 r_out, n_out;

    logic [CW-1:0]             eff_n;
    logic                      spr_zero;
    logic                      n_zero;
    logic                      in_xfer;
    logic                      slot_free;

    logic [SW-1:0]             mul_a;
    logic [CW-1:0]             mul_b;
    logic [SW+CW-1:0]          prod;
    logic [NW-1:0]             acc_in;

    logic signed [VW-1:0]      wrap_v;
    logic [MAGW-1:0]           wrap_mag;
    logic                      wrap_direct;
    logic [SW-1:0]             rem_s;
    logic [SW-1:0]             wrap_pos;

    logic [CW-1:0]             q_sel;
    logic [CW:0]               q_inc;
    logic [CW-1:0]             step_idx;

    logic signed [RW-1:0]      spr_s;
    logic signed [RW-1:0]      half_s;
    logic signed [RW-1:0]      route;

    logic                      div_start;
    logic [NW-1:0]             div_num;
    logic [LW-1:0]             div_len;
    logic [DW-1:0]             div_den;
    logic                      div_done;
    logic [SW-1:0]             div_quo;
    logic [DW-1:0]             div_rem;
    logic [CW-1:0]             div_qmod;

    // Clamp the index count to the supported maximum
    assign eff_n    = (r_ppr > CW'(MAXC)) ? CW'(MAXC) : r_ppr;
    assign spr_zero = (r_spr == '0);
    assign n_zero   = (eff_n == '0);

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign slot_free = !r_ovalid || !i_out_stall;

    // Shared multiplier: position times count, or steps per rev times index
    always_comb begin
        mul_a = r_pos;
        mul_b = eff_n;
        if (r_job == J_TARGET) begin
            mul_a = r_spr;
            mul_b = r_idx;
        end
    end
    assign prod = mul_a * mul_b;

    // Position plus completed steps, and its magnitude for the remainder
    assign wrap_v      = $signed({{(VW-SW){1'b0}}, r_pos}) + VW'(r_done_steps);
    assign wrap_mag    = wrap_v[VW-1] ? MAGW'(-wrap_v) : MAGW'(wrap_v);
    assign wrap_direct = !wrap_v[VW-1] && (wrap_mag < MAGW'(r_spr));
    assign rem_s       = div_rem[SW-1:0];
    assign wrap_pos    = (wrap_v[VW-1] && (rem_s != '0)) ? r_spr - rem_s : rem_s;

    // Neighbor index from the nearest index, wrapping around
    assign q_sel = (r_state == S_DIV) ? div_qmod : '0;
    assign q_inc = {1'b0, q_sel} + (CW+1)'(1);
    always_comb begin
        if (r_op == OP_PREV) begin
            step_idx = (q_sel == '0) ? eff_n - CW'(1) : q_sel - CW'(1);
        end else begin
            step_idx = (q_inc >= {1'b0, eff_n}) ? '0 : q_inc[CW-1:0];
        end
    end

    // Shortest route: fold the difference into plus or minus half a revolution
    assign spr_s  = $signed({2'b00, r_spr});
    assign half_s = $signed({3'b000, r_spr[SW-1:1]});
    always_comb begin
        if (r_diff > half_s) begin
            route = r_diff - spr_s;
        end else if (r_diff < -half_s) begin
            route = r_diff + spr_s;
        end else begin
            route = r_diff;
        end
    end

    // Operand selection for the divider run
    always_comb begin
        case (r_job)
            J_POSMOD: acc_in = NW'(r_pos);
            J_TGTMOD: acc_in = NW'(r_ptgt);
            J_WRAP:   acc_in = NW'(wrap_mag);
            default:  acc_in = NW'(prod);
        endcase
    end

    always_comb begin
        div_num = r_acc;
        div_len = LW'(SW);
        div_den = DW'(r_spr);
        case (r_job)
            J_NEAR_PRE, J_NEAR_OUT: begin
                div_num = r_acc + NW'(r_spr[SW-1:1]);
                div_len = LW'(SW + CW);
            end
            J_TARGET: begin
                div_num = {r_acc[NW-2:0], 1'b0} + NW'(eff_n);
                div_len = LW'(SW + CW + 1);
                div_den = DW'({eff_n, 1'b0});
            end
            J_WRAP: begin
                div_len = LW'(FIELD_W + 1);
            end
            default: begin
                div_len = LW'(SW);
            end
        endcase
    end

    assign div_start = (r_state == S_ADD);

    rip_serial_div #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (SW),
        .MOD_W (CW),
        .LEN_W (LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_len   (div_len),
        .i_den   (div_den),
        .i_modn  (eff_n),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_qmod  (div_qmod)
    );

    // Command sequencer
    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_spr        = r_spr;
        n_ppr        = r_ppr;
        n_pos        = r_pos;
        n_ptgt       = r_ptgt;
        n_preq       = r_preq;
        n_pend       = r_pend;
        n_op         = r_op;
        n_idx        = r_idx;
        n_done_steps = r_done_steps;
        n_acc        = r_acc;
        n_pm         = r_pm;
        n_diff       = r_diff;
        n_status     = r_status;
        n_near       = r_near;
        n_out        = r_out;
        n_ovalid     = r_ovalid && i_out_stall;

        // Register writes
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_STEPS_PER_REV) begin
                n_spr = i_cfg_data[SW-1:0];
            end else if (i_cfg_index == REG_POSITIONS_PER_REV) begin
                n_ppr = i_cfg_data[CW-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op         = i_in_data.op;
                    n_idx        = CW'(i_in_data.target_index);
                    n_done_steps = i_in_data.completed_steps;
                    n_state      = S_PLAN;
                end
            end

            S_PLAN: begin
                case (r_op)
                    OP_MOVE: begin
                        n_state = S_START;
                    end
                    OP_NEXT, OP_PREV: begin
                        if (spr_zero || n_zero) begin
                            n_idx   = step_idx;
                            n_state = S_START;
                        end else begin
                            n_job   = J_NEAR_PRE;
                            n_state = S_MUL;
                        end
                    end
                    OP_ZERO: begin
                        n_pos    = '0;
                        n_pend   = 1'b0;
                        n_status = ST_ZEROED;
                        n_near   = '0;
                        n_state  = S_FIN;
                    end
                    OP_REPORT: begin
                        if (!r_pend) begin
                            n_status = ST_NONE;
                            n_state  = S_NEAR;
                        end else begin
                            n_pend   = 1'b0;
                            n_status = (r_done_steps == r_preq) ? ST_COMPLETE : ST_STOPPED;
                            if (spr_zero) begin
                                n_pos   = '0;
                                n_state = S_NEAR;
                            end else if (r_done_steps == r_preq) begin
                                if (r_ptgt < r_spr) begin
                                    n_pos   = r_ptgt;
                                    n_state = S_NEAR;
                                end else begin
                                    n_job   = J_TGTMOD;
                                    n_state = S_MUL;
                                end
                            end else if (wrap_direct) begin
                                n_pos   = SW'(wrap_mag);
                                n_state = S_NEAR;
                            end else begin
                                n_job   = J_WRAP;
                                n_state = S_MUL;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_NONE;
                        n_state  = S_NEAR;
                    end
                endcase
            end

            // Validate the index and launch the target computation
            S_START: begin
                n_pend = 1'b0;
                if (n_zero || (r_idx >= eff_n)) begin
                    n_status = ST_BAD_INDEX;
                    n_state  = S_NEAR;
                end else if (spr_zero) begin
                    n_status = ST_BAD_CAL;
                    n_state  = S_NEAR;
                end else if (r_pos < r_spr) begin
                    n_pm    = r_pos;
                    n_job   = J_TARGET;
                    n_state = S_MUL;
                end else begin
                    n_job   = J_POSMOD;
                    n_state = S_MUL;
                end
            end

            S_MUL: begin
                n_acc   = acc_in;
                n_state = S_ADD;
            end

            S_ADD: begin
                n_state = S_DIV;
            end

            // Take the divider result and advance to the next job
            S_DIV: begin
                if (div_done) begin
                    case (r_job)
                        J_NEAR_PRE: begin
                            n_idx   = step_idx;
                            n_state = S_START;
                        end
                        J_POSMOD: begin
                            n_pm    = rem_s;
                            n_job   = J_TARGET;
                            n_state = S_MUL;
                        end
                        J_TARGET: begin
                            n_ptgt  = div_quo;
                            n_diff  = $signed({2'b00, div_quo}) - $signed({2'b00, r_pm});
                            n_state = S_ROUTE;
                        end
                        J_WRAP: begin
                            n_pos   = wrap_pos;
                            n_state = S_NEAR;
                        end
                        J_TGTMOD: begin
                            n_pos   = rem_s;
                            n_state = S_NEAR;
                        end
                        J_NEAR_OUT: begin
                            n_near  = div_qmod;
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_ROUTE: begin
                n_preq   = FIELD_W'(route);
                n_pend   = 1'b1;
                n_status = ST_MOVE;
                n_state  = S_NEAR;
            end

            // Nearest index of the final position
            S_NEAR: begin
                if (spr_zero || n_zero) begin
                    n_near  = '0;
                    n_state = S_FIN;
                end else begin
                    n_job   = J_NEAR_OUT;
                    n_state = S_MUL;
                end
            end

            // Load the output register once it is free
            S_FIN: begin
                if (slot_free) begin
                    n_out.requested_steps = (r_status == ST_MOVE) ? r_preq : '0;
                    n_out.status          = r_status;
                    n_out.position_steps  = FIELD_W'(r_pos);
                    n_out.nearest_index   = r_near[IDX_W-1:0];
                    n_ovalid              = 1'b1;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_spr    <= SW'(SPR_RESET);
            r_ppr    <= CW'(PPR_RESET);
            r_pos    <= '0;
            r_ptgt   <= '0;
            r_preq   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_spr    <= n_spr;
            r_ppr    <= n_ppr;
            r_pos    <= n_pos;
            r_ptgt   <= n_ptgt;
            r_preq   <= n_preq;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_done_steps <= n_done_steps;
        r_acc        <= n_acc;
        r_pm         <= n_pm;
        r_diff       <= n_diff;
        r_status     <= n_status;
        r_near       <= n_near;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    `RIP_ASSERT_IMP(a_req_only_on_move,
        r_ovalid && (r_out.status != ST_MOVE), r_out.requested_steps == '0,
        "step request on a result that is not a move")
    `RIP_ASSERT_NXT(a_xfer_starts_plan, in_xfer, r_state == S_PLAN,
        "accepted command did not start planning")
    `RIP_ASSERT_IMP(a_div_done_waiting, div_done, r_state == S_DIV,
        "divider finished outside the wait state")

endmodule

### tb/rotary_indexer_position_tracker_top_tb.sv
module rotary_indexer_position_tracker_top_tb;
    import rip_pkg::*;

    localparam int STEP_BITS     = 24;
    localparam int MAX_POSITIONS = 64;

    // Op codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    // Track indexer state and hold the results it must produce, oldest first
    class indexer_scoreboard;
        logic [FIELD_W-1:0] steps_per_rev;
        logic [COUNT_W-1:0] positions_per_rev;
        longint             position;
        longint             target_step;
        longint             pend_req;
        bit                 move_pending;
        t_out_item          expected_q[$];
        int                 errors;
        int                 results;
        int                 transfers;
        int                 settings;
        int                 status_count[8];

        function new();
            steps_per_rev     = SPR_RESET;
            positions_per_rev = PPR_RESET;
            position          = 0;
            target_step       = 0;
            pend_req          = 0;
            move_pending      = 1'b0;
            errors            = 0;
            results           = 0;
            transfers         = 0;
            settings          = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
            if (idx == REG_STEPS_PER_REV)
                steps_per_rev = data;
            else
                positions_per_rev = data[COUNT_W-1:0];
        endfunction

        // Clamp the configured count to what the block supports
        function longint index_count();
            return (positions_per_rev > MAX_POSITIONS) ? longint'(MAX_POSITIONS)
                                                       : longint'(positions_per_rev);
        endfunction

        function longint wrap_rev(longint v);
            longint s;
            longint r;
            s = longint'(steps_per_rev);
            if (s == 0)
                return 0;
            r = v % s;
            if (r < 0)
                r += s;
            return r;
        endfunction

        function longint nearest_of(longint p);
            longint s;
            longint n;
            s = longint'(steps_per_rev);
            n = index_count();
            if (s == 0 || n == 0)
                return 0;
            return ((p * n + s / 2) / s) % n;
        endfunction

        // Validate the index, round the target half up, take the shorter way around
        function logic [STATUS_W-1:0] begin_move(longint idx, output longint req);
            longint n;
            longint s;
            longint tgt;
            longint r;
            longint half;
            n            = index_count();
            s            = longint'(steps_per_rev);
            move_pending = 1'b0;
            req          = 0;
            if (idx < 0 || idx >= n)
                return ST_BAD_INDEX;
            if (s == 0)
                return ST_BAD_CAL;
            tgt  = (idx * s * 2 + n) / (2 * n);
            r    = tgt - wrap_rev(position);
            half = s / 2;
            if (r > half)
                r -= s;
            else if (r < -half)
                r += s;
            target_step  = tgt & ((longint'(1) << STEP_BITS) - 1);
            pend_req     = r;
            move_pending = 1'b1;
            req          = r;
            return ST_MOVE;
        endfunction

        // Advance the state for one accepted command and queue its result
        function void note_command(t_in_item it);
            t_out_item           e;
            longint              req;
            longint              idx;
            longint              done;
            logic [STATUS_W-1:0] st;
            req = 0;
            st  = ST_NONE;
            case (it.op)
                OP_MOVE: begin
                    st = begin_move(longint'(it.target_index), req);
                end
                OP_NEXT: begin
                    idx = nearest_of(position) + 1;
                    if (idx >= index_count())
                        idx = 0;
                    st = begin_move(idx, req);
                end
                OP_PREV: begin
                    idx = nearest_of(position) - 1;
                    if (idx < 0)
                        idx = index_count() - 1;
                    st = begin_move(idx, req);
                end
                OP_ZERO: begin
                    position     = 0;
                    move_pending = 1'b0;
                    st           = ST_ZEROED;
                end
                OP_REPORT: begin
                    if (move_pending) begin
                        done     = longint'($signed(it.completed_steps));
                        position = wrap_rev(position + done);
                        if (done == pend_req) begin
                            position = wrap_rev(target_step);
                            st       = ST_COMPLETE;
                        end else begin
                            st = ST_STOPPED;
                        end
                        move_pending = 1'b0;
                    end
                end
                default: ;
            endcase
            if (st != ST_MOVE)
                req = 0;
            e.requested_steps = FIELD_W'(req);
            e.status          = st;
            e.position_steps  = FIELD_W'(position);
            e.nearest_index   = IDX_W'(nearest_of(position));
            expected_q.push_back(e);
            status_count[st]++;
            transfers++;
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("MISMATCH result %0d %s: got %0d, expected %0d",
                     results, what, got, want);
        endtask

        // Compare one accepted result against the oldest expectation
        task check_result(t_out_item got);
            t_out_item e;
            results++;
            if (expected_q.size() == 0) begin
                report("unexpected result, status", got.status, -1);
                return;
            end
            e = expected_q.pop_front();
            if (got.requested_steps !== e.requested_steps)
                report("requested_steps", longint'($signed(got.requested_steps)),
                       longint'($signed(e.requested_steps)));
            if (got.status !== e.status)
                report("status", got.status, e.status);
            if (got.position_steps !== e.position_steps)
                report("position_steps", got.position_steps, e.position_steps);
            if (got.nearest_index !== e.nearest_index)
                report("nearest_index", got.nearest_index, e.nearest_index);
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data  = '0;

    int sender_idle_pct   = 29;
    int receiver_idle_pct = 61;

    indexer_scoreboard sb = new();

    rotary_indexer_position_tracker_top #(
        .STEP_BITS     (STEP_BITS),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Present one command, hold it until the transfer, then maybe idle
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(it);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] steps);
        t_in_item it;
        it.op              = op;
        it.target_index    = idx;
        it.completed_steps = steps;
        send_item(it);
    endtask

    // Drop valid and wait until every queued result has transferred
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [FIELD_W-1:0] spr, input logic [COUNT_W-1:0] ppr);
        cfg_write(REG_STEPS_PER_REV, spr);
        cfg_write(REG_POSITIONS_PER_REV, FIELD_W'(ppr));
        i_cfg_valid <= 1'b0;
        sb.settings++;
    endtask

    // Mostly move-then-report pairs with random content, plus noise
    function automatic t_in_item random_command();
        t_in_item it;
        int       pick;
        longint   n;
        it.op              = OP_MOVE;
        it.target_index    = IDX_W'($urandom_range(63));
        it.completed_steps = FIELD_W'($urandom);
        n                  = sb.index_count();
        if (sb.move_pending && $urandom_range(99) < 70) begin
            it.op = OP_REPORT;
            pick  = $urandom_range(99);
            if (pick < 60)
                it.completed_steps = FIELD_W'(sb.pend_req);
            else if (pick < 80)
                it.completed_steps = FIELD_W'(sb.pend_req + longint'($urandom_range(6)) - 3);
        end else begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (n > 0 && $urandom_range(99) < 85)
                    it.target_index = IDX_W'($urandom_range(int'(n) - 1));
            end else if (pick < 65) begin
                it.op = OP_NEXT;
            end else if (pick < 80) begin
                it.op = OP_PREV;
            end else if (pick < 87) begin
                it.op = OP_ZERO;
            end else if (pick < 93) begin
                it.op = OP_REPORT;
            end else begin
                it.op = OP_W'($urandom_range(OP_RSVD7, OP_RSVD5));
            end
        end
        return it;
    endfunction

    initial begin
        t_in_item           it;
        bit                 counted;
        int                 n_items;
        int                 done_items;
        logic [FIELD_W-1:0] spr_v;
        logic [COUNT_W-1:0] ppr_v;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: report with nothing pending, zero-length move, wraps
        send_op(OP_REPORT, 6'd63, 24'h7FFFFF);
        send_op(OP_MOVE, 6'd0, 24'h000000);
        send_op(OP_REPORT, 6'd0, 24'h000000);
        send_op(OP_MOVE, 6'd4, 24'h000000);
        send_op(OP_REPORT, 6'd0, FIELD_W'(sb.pend_req));
        send_op(OP_NEXT, 6'd0, 24'h000000);
        send_op(OP_REPORT, 6'd0, 24'h800000);
        send_op(OP_PREV, 6'd0, 24'h000000);
        // Out-of-range index cancels the pending move
        send_op(OP_MOVE, 6'd63, 24'h000000);
        send_op(OP_REPORT, 6'd0, 24'h000005);
        send_op(OP_RSVD5, 6'h2A, 24'h555555);
        send_op(OP_RSVD6, 6'h15, 24'hAAAAAA);
        send_op(OP_RSVD7, 6'h3F, 24'hFFFFFF);
        send_op(OP_ZERO, 6'd63, 24'hFFFFFF);
        send_op(OP_MOVE, 6'd3, 24'h000000);
        wait_for_results();

        // Lose calibration while a move is pending
        configure(24'd0, 7'd6);
        send_op(OP_REPORT, 6'd0, 24'd100);
        send_op(OP_MOVE, 6'd2, 24'h000000);
        send_op(OP_NEXT, 6'd0, 24'h000000);
        wait_for_results();

        // No index positions at all
        configure(24'd3200, 7'd0);
        send_op(OP_MOVE, 6'd0, 24'h000000);
        send_op(OP_PREV, 6'd0, 24'h000000);
        send_op(OP_NEXT, 6'd0, 24'h000000);
        wait_for_results();

        // Count above the supported maximum
        configure(24'd3200, 7'd127);
        send_op(OP_MOVE, 6'd63, 24'h000000);
        send_op(OP_REPORT, 6'd0, FIELD_W'(sb.pend_req));
        wait_for_results();

        // Position now lies beyond the shorter revolution
        configure(24'd1000, 7'd64);
        send_op(OP_NEXT, 6'd0, 24'h000000);
        send_op(OP_REPORT, 6'd0, FIELD_W'(sb.pend_req));
        wait_for_results();

        configure(24'hFFFFFF, 7'd1);
        send_op(OP_MOVE, 6'd0, 24'h000000);
        send_op(OP_PREV, 6'd0, 24'h000000);
        send_op(OP_REPORT, 6'd0, FIELD_W'(sb.pend_req));
        wait_for_results();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 12; ph++) begin
            n_items = 80;
            case (ph)
                0:  begin spr_v = 24'd3200;    ppr_v = 7'd6;   end
                1:  begin spr_v = 24'd200;     ppr_v = 7'd64;  end
                2:  begin spr_v = 24'd7;       ppr_v = 7'd3;   end
                3:  begin spr_v = 24'hFFFFFF;  ppr_v = 7'd64;  end
                4:  begin spr_v = 24'd1;       ppr_v = 7'd6;   end
                5:  begin
                    spr_v = FIELD_W'($urandom_range(24'hFFFFFF));
                    ppr_v = 7'd127;
                end
                6:  begin spr_v = 24'd0;       ppr_v = 7'd8;   n_items = 27; end
                7:  begin spr_v = 24'd5000;    ppr_v = 7'd0;   n_items = 27; end
                8:  begin
                    spr_v = FIELD_W'($urandom_range(4096, 1));
                    ppr_v = COUNT_W'($urandom_range(64, 1));
                end
                9:  begin spr_v = 24'h800000;  ppr_v = 7'd37;  end
                10: begin
                    spr_v = FIELD_W'($urandom_range(24'hFFFFFF));
                    ppr_v = COUNT_W'($urandom_range(127));
                end
                default: begin spr_v = 24'd3200; ppr_v = 7'd6; end
            endcase
            if (ph < 4) begin
                sender_idle_pct   = 29;
                receiver_idle_pct = 61;
            end else if (ph < 8) begin
                sender_idle_pct   = 61;
                receiver_idle_pct = 29;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            configure(spr_v, ppr_v);
            done_items = 0;
            while (done_items < n_items) begin
                it      = random_command();
                counted = (it.op <= OP_ZERO) || (it.op == OP_REPORT && sb.move_pending);
                send_item(it);
                if (counted)
                    done_items++;
            end
            wait_for_results();
        end

        // Let any stray result show up before closing
        repeat (150) @(posedge i_clk);

        $display("Ran %0d command transfers and checked %0d results over %0d settings",
                 sb.transfers, sb.results, sb.settings);
        $display("Moves %0d, bad index %0d, bad cal %0d, complete %0d, stopped %0d, zeroed %0d",
                 sb.status_count[ST_MOVE], sb.status_count[ST_BAD_INDEX],
                 sb.status_count[ST_BAD_CAL], sb.status_count[ST_COMPLETE],
                 sb.status_count[ST_STOPPED], sb.status_count[ST_ZEROED]);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
